>>> sv/dual_channel_offset_amplitude_estimator_unit_macros.svh
// Assertion macros for the offset and amplitude estimator.
// Included by the checker file; depends on nothing else.
`ifndef DUAL_CHANNEL_OFFSET_AMPLITUDE_ESTIMATOR_UNIT_MACROS_SVH
`define DUAL_CHANNEL_OFFSET_AMPLITUDE_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCOAE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcoae assertion failed");

// Next-cycle implication, disabled during reset.
`define DCOAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcoae assertion failed");

`endif

>>> sv/dcoae_pkg.sv
// Shared types and constants of the offset and amplitude estimator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dcoae_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int FRAC_BITS    = 20;
  localparam int MEAN_W       = SAMPLE_BITS + FRAC_BITS;
  localparam int HALF_W       = SAMPLE_BITS - 1;
  localparam int ALPHA_W      = 11;
  localparam int NUM_LANES    = 2;
  localparam int FRAME_LEN_W  = 16;

  // Smoothing factor 1049 / 2^20, close to 0.001.
  localparam logic [ALPHA_W-1:0] ALPHA_NUM = 11'd1049;

  // Half of full scale (511.5) in Q10.20.
  localparam logic [MEAN_W-1:0] MEAN_RESET =
    {1'b0, {SAMPLE_BITS{1'b1}}, {(FRAC_BITS-1){1'b0}}};

  localparam logic [SAMPLE_BITS-1:0] MIN_RESET = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] MAX_RESET = '0;

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 16'd4000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
  } sample_t;

  typedef struct packed {
    logic [HALF_W-1:0]      half_range_a;
    logic [HALF_W-1:0]      half_range_b;
    logic [SAMPLE_BITS-1:0] centre_a;
    logic [SAMPLE_BITS-1:0] centre_b;
  } result_t;

  // Per-transaction control shared by all lanes.
  typedef struct packed {
    logic accept;
    logic frame_end;
  } lane_ctl_t;

  // What one lane hands to the merge stage at frame end.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] min_val;
    logic [SAMPLE_BITS-1:0] max_val;
    logic [SAMPLE_BITS-1:0] mean_int;
  } snap_t;

endpackage

`default_nettype wire

>>> sv/dual_channel_offset_amplitude_estimator_unit.sv
// Top level of the dual-channel offset and amplitude estimator.
// Depends on dcoae_pkg, dcoae_lane and dcoae_merge.
//
//  channel   handshake                 payload             direction
//  -------   -----------------------   -----------------   ---------
//  sample    sample_valid/sample_stall  sample (sample_t)   in
//  result    result_valid/result_stall  result (result_t)   out
//  cfg       cfg_valid/cfg_ready        cfg_data [15:0]     in
//
// One sample pair is taken every cycle while sample_stall is low; the mean update
// (subtract, constant multiply, add) is combinational inside each lane.
// A frame-ending transaction's figures are registered in the lane snapshot,
// then in the merge output register, which shows the result.
// Reset (rst, synchronous) loads the mean to 511.5, min/max to their
// extremes, the count to zero and frame_length to 4000.
// sample_stall rises only when a result waits in the output register under
// result_stall and a second snapshot is already queued behind it.
`default_nettype none

module dual_channel_offset_amplitude_estimator_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire dcoae_pkg::sample_t                  sample,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output dcoae_pkg::result_t                       result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dcoae_pkg::FRAME_LEN_W-1:0]   cfg_data
);

  localparam int LW = dcoae_pkg::FRAME_LEN_W;

  logic [LW-1:0]          frame_length;
  logic [LW-1:0]          sample_count;
  logic [LW-1:0]          count_next;
  logic [LW-1:0]          limit;
  logic                   accept;
  logic                   frame_end;
  logic                   snap_valid;
  logic                   take;
  dcoae_pkg::lane_ctl_t   lane_ctl;
  dcoae_pkg::snap_t       snap [dcoae_pkg::NUM_LANES];
  logic [dcoae_pkg::SAMPLE_BITS-1:0] lane_x [dcoae_pkg::NUM_LANES];

  // Configuration is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= dcoae_pkg::FRAME_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_length <= cfg_data;
    end
  end

  // Hold input only when both the output register and the snapshot are full
  // and the output is stalled.
  assign sample_stall = snap_valid && result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  // A zero frame length acts as one; a wrapped count also closes the frame.
  always_comb begin
    count_next = sample_count + 1'b1;
    limit      = (frame_length == '0) ? {{(LW-1){1'b0}}, 1'b1} : frame_length;
    frame_end  = (count_next >= limit) || (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (accept) begin
      sample_count <= frame_end ? '0 : count_next;
    end
  end

  // Snapshot stage valid: set on a frame end, drop when merge takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && frame_end) begin
      snap_valid <= 1'b1;
    end else if (take) begin
      snap_valid <= 1'b0;
    end
  end

  assign lane_ctl.accept    = accept;
  assign lane_ctl.frame_end = frame_end;
  assign lane_x[0]          = sample.sample_a;
  assign lane_x[1]          = sample.sample_b;

  // One lane per channel.
  for (genvar g = 0; g < dcoae_pkg::NUM_LANES; g++) begin : g_lane
    dcoae_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (lane_ctl),
      .x    (lane_x[g]),
      .snap (snap[g])
    );
  end

  dcoae_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .snap         (snap),
    .snap_valid   (snap_valid),
    .result_stall (result_stall),
    .result       (result),
    .result_valid (result_valid),
    .take         (take)
  );

endmodule

`default_nettype wire

>>> sv/dcoae_lane.sv
// One channel lane: running mean, frame min/max and frame-end snapshot.
// Depends on dcoae_pkg.
`default_nettype none

module dcoae_lane (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire dcoae_pkg::lane_ctl_t            ctl,
  input  wire logic [dcoae_pkg::SAMPLE_BITS-1:0] x,
  output dcoae_pkg::snap_t                     snap
);

  localparam int MW     = dcoae_pkg::MEAN_W;
  localparam int SB     = dcoae_pkg::SAMPLE_BITS;
  localparam int FB     = dcoae_pkg::FRAC_BITS;
  localparam int DIFF_W = MW + 1;
  localparam int PROD_W = DIFF_W + dcoae_pkg::ALPHA_W + 1;
  localparam int STEP_W = PROD_W - FB;

  logic [MW-1:0]            mean;
  logic [MW-1:0]            mean_next;
  logic [SB-1:0]            min_val;
  logic [SB-1:0]            max_val;
  logic [SB-1:0]            min_upd;
  logic [SB-1:0]            max_upd;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [STEP_W-1:0]        step;

  // mean += floor((x - mean) * alpha); the arithmetic shift gives the floor.
  always_comb begin
    diff      = $signed({1'b0, x, {FB{1'b0}}}) - $signed({1'b0, mean});
    prod      = diff * $signed({1'b0, dcoae_pkg::ALPHA_NUM});
    step      = prod[PROD_W-1:FB];
    mean_next = mean + {{(MW-STEP_W){step[STEP_W-1]}}, step};
    min_upd   = (x < min_val) ? x : min_val;
    max_upd   = (x > max_val) ? x : max_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean    <= dcoae_pkg::MEAN_RESET;
      min_val <= dcoae_pkg::MIN_RESET;
      max_val <= dcoae_pkg::MAX_RESET;
    end else if (ctl.accept) begin
      mean <= mean_next;
      if (ctl.frame_end) begin
        min_val <= dcoae_pkg::MIN_RESET;
        max_val <= dcoae_pkg::MAX_RESET;
      end else begin
        min_val <= min_upd;
        max_val <= max_upd;
      end
    end
  end

  // Capture the closing frame's figures.
  always_ff @(posedge clk) begin
    if (ctl.accept && ctl.frame_end) begin
      snap.min_val  <= min_upd;
      snap.max_val  <= max_upd;
      snap.mean_int <= mean_next[MW-1:FB];
    end
  end

endmodule

`default_nettype wire

>>> sv/dcoae_merge.sv
// Merge stage: combines lane snapshots into one result and holds it.
// Depends on dcoae_pkg.
`default_nettype none

module dcoae_merge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dcoae_pkg::snap_t   snap [dcoae_pkg::NUM_LANES],
  input  wire logic               snap_valid,
  input  wire logic               result_stall,
  output dcoae_pkg::result_t      result,
  output logic                    result_valid,
  output logic                    take
);

  localparam int SB = dcoae_pkg::SAMPLE_BITS;
  localparam int HW = dcoae_pkg::HALF_W;

  logic [SB:0]   mid_sum    [dcoae_pkg::NUM_LANES];
  logic [SB:0]   centre_sum [dcoae_pkg::NUM_LANES];
  logic [SB-1:0] span       [dcoae_pkg::NUM_LANES];
  logic [HW-1:0] half       [dcoae_pkg::NUM_LANES];
  logic [SB-1:0] centre     [dcoae_pkg::NUM_LANES];

  always_comb begin
    for (int i = 0; i < dcoae_pkg::NUM_LANES; i++) begin
      span[i]       = snap[i].max_val - snap[i].min_val;
      half[i]       = span[i][SB-1:1];
      mid_sum[i]    = {1'b0, snap[i].max_val} + {1'b0, snap[i].min_val};
      centre_sum[i] = {1'b0, mid_sum[i][SB:1]} + {1'b0, snap[i].mean_int};
      centre[i]     = centre_sum[i][SB:1];
    end
  end

  // Advance the snapshot when the output register is free or being emptied.
  assign take = snap_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.half_range_a <= half[0];
      result.half_range_b <= half[1];
      result.centre_a     <= centre[0];
      result.centre_b     <= centre[1];
    end
  end

endmodule

`default_nettype wire

>>> sv/dcoae_checker.sv
// Port-level checker for the estimator top level, bound to it below.
// Depends on dcoae_pkg and the assertion macro header.
`default_nettype none

`include "dual_channel_offset_amplitude_estimator_unit_macros.svh"

module dcoae_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               sample_valid,
  input wire logic               sample_stall,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire dcoae_pkg::result_t result
);

  // A stalled result transaction stays offered and unchanged.
  `DCOAE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // Input backpressure only comes from a full, stalled output.
  `DCOAE_ASSERT_NOW(a_stall_cause, sample_stall, result_valid && result_stall)

  // A fresh result traces back to an accepted sample pair via the lane snapshot and merge output register.
  `DCOAE_ASSERT_NOW(a_result_origin, $rose(result_valid), $past(sample_valid && !sample_stall, 2))

endmodule

bind dual_channel_offset_amplitude_estimator_unit dcoae_checker u_dcoae_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the dual-channel offset and amplitude estimator.
// Depends on dcoae_pkg and dual_channel_offset_amplitude_estimator_unit; a built-in
// predictor tracks the running means and per-frame min/max and checks every frame report.
`default_nettype none

module testbench;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PAIRS  = 850;

  localparam int SAMPLE_BITS = dcoae_pkg::SAMPLE_BITS;
  localparam int FRAC_BITS   = dcoae_pkg::FRAC_BITS;
  localparam int MEAN_W      = dcoae_pkg::MEAN_W;
  localparam int HALF_W      = dcoae_pkg::HALF_W;
  localparam int FRAME_LEN_W = dcoae_pkg::FRAME_LEN_W;

  localparam logic [MEAN_W-1:0]      MEAN_RESET      = dcoae_pkg::MEAN_RESET;
  localparam logic [SAMPLE_BITS-1:0] MIN_RESET       = dcoae_pkg::MIN_RESET;
  localparam logic [SAMPLE_BITS-1:0] MAX_RESET       = dcoae_pkg::MAX_RESET;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = dcoae_pkg::FRAME_LEN_RESET;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  dcoae_pkg::sample_t     sample       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  dcoae_pkg::result_t     result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [FRAME_LEN_W-1:0] cfg_data     = '0;

  // Predictor state: the means persist across frames, min/max and count do not.
  logic [MEAN_W-1:0]      mean_a    = MEAN_RESET;
  logic [MEAN_W-1:0]      mean_b    = MEAN_RESET;
  logic [SAMPLE_BITS-1:0] low_a     = MIN_RESET;
  logic [SAMPLE_BITS-1:0] high_a    = MAX_RESET;
  logic [SAMPLE_BITS-1:0] low_b     = MIN_RESET;
  logic [SAMPLE_BITS-1:0] high_b    = MAX_RESET;
  logic [FRAME_LEN_W-1:0] pair_count = '0;
  logic [FRAME_LEN_W-1:0] frame_len  = FRAME_LEN_RESET;

  dcoae_pkg::sample_t sample_backlog[$];
  dcoae_pkg::result_t frame_reports[$];
  dcoae_pkg::result_t wanted_report;

  int queued_pairs   = 0;
  int accepted_pairs = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  bit steady         = 1'b0;

  dual_channel_offset_amplitude_estimator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // One smoothing step: add floor((x - mean) * alpha), alpha = ALPHA_NUM / 2^FRAC_BITS.
  function automatic logic [MEAN_W-1:0] nudge_mean(logic [MEAN_W-1:0] m,
                                                   logic [SAMPLE_BITS-1:0] x);
    longint gap;
    longint step;
    gap  = longint'({x, {FRAC_BITS{1'b0}}}) - longint'(m);
    step = (gap * longint'(dcoae_pkg::ALPHA_NUM)) >>> FRAC_BITS;
    return MEAN_W'(longint'(m) + step);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] to_code(int v);
    if (v < 0) return '0;
    if (v > int'(MIN_RESET)) return MIN_RESET;
    return SAMPLE_BITS'(v);
  endfunction

  // Fold one accepted pair into the predictor; queue a report when the frame closes.
  task automatic absorb_pair(input dcoae_pkg::sample_t s);
    dcoae_pkg::result_t r;
    int unsigned        lim;
    mean_a = nudge_mean(mean_a, s.sample_a);
    mean_b = nudge_mean(mean_b, s.sample_b);
    if (s.sample_a < low_a)  low_a  = s.sample_a;
    if (s.sample_a > high_a) high_a = s.sample_a;
    if (s.sample_b < low_b)  low_b  = s.sample_b;
    if (s.sample_b > high_b) high_b = s.sample_b;
    pair_count = pair_count + 1'b1;
    // A zero length acts as one; a shrunk length closes the frame at once.
    lim = (frame_len == '0) ? 1 : frame_len;
    if (pair_count >= lim || pair_count == '0) begin
      r.half_range_a = HALF_W'((int'(high_a) - int'(low_a)) >> 1);
      r.half_range_b = HALF_W'((int'(high_b) - int'(low_b)) >> 1);
      r.centre_a = SAMPLE_BITS'((((int'(high_a) + int'(low_a)) >> 1)
                                 + int'(mean_a[MEAN_W-1:FRAC_BITS])) >> 1);
      r.centre_b = SAMPLE_BITS'((((int'(high_b) + int'(low_b)) >> 1)
                                 + int'(mean_b[MEAN_W-1:FRAC_BITS])) >> 1);
      frame_reports.push_back(r);
      low_a      = MIN_RESET;
      high_a     = MAX_RESET;
      low_b      = MIN_RESET;
      high_b     = MAX_RESET;
      pair_count = '0;
    end
  endtask

  task automatic queue_pair(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b);
    dcoae_pkg::sample_t s;
    s.sample_a = a;
    s.sample_b = b;
    sample_backlog.push_back(s);
    queued_pairs++;
  endtask

  // Write frame_length; the block is idle whenever this is called.
  task automatic write_frame_length(input logic [FRAME_LEN_W-1:0] v);
    @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_len = v;
  endtask

  // Hold until every queued pair is taken and every report is back, then let the
  // pipeline settle so a pair that closed no frame is fully absorbed.
  task automatic drain();
    do @(posedge clk); while (accepted_pairs != queued_pairs || frame_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sample driver: advance to the next pair only once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        absorb_pair(sample);
        accepted_pairs++;
      end
      if (!sample_valid || !sample_stall) begin
        if (sample_backlog.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
          sample       <= sample_backlog.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each report with the oldest prediction, stall at random outside steady phases.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (frame_reports.size() == 0) begin
          if (mismatches < 10) $display("unexpected frame report: %p", result);
          mismatches++;
        end else begin
          wanted_report = frame_reports.pop_front();
          if (wanted_report.half_range_a !== result.half_range_a ||
              wanted_report.half_range_b !== result.half_range_b ||
              wanted_report.centre_a     !== result.centre_a     ||
              wanted_report.centre_b     !== result.centre_b) begin
            if (mismatches < 10)
              $display("frame report mismatch: expected %p, got %p", wanted_report, result);
            mismatches++;
          end
        end
      end
      result_stall <= !steady && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int                     n;
    int                     style;
    int                     cen_a;
    int                     cen_b;
    int                     amp;
    int                     pick;
    int                     phase;
    int                     random_pairs;
    logic [FRAME_LEN_W-1:0] len;
    logic [SAMPLE_BITS-1:0] a;
    logic [SAMPLE_BITS-1:0] b;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset length is 4000: none of these may close a frame.
    queue_pair(10'd0, 10'd1023);
    queue_pair(10'd1023, 10'd0);
    queue_pair(10'd0, 10'd0);
    queue_pair(10'd1023, 10'd1023);
    queue_pair(10'h155, 10'h2AA);
    queue_pair(10'h2AA, 10'h155);
    queue_pair(10'd512, 10'd511);
    queue_pair(10'd1, 10'd1022);
    queue_pair(10'd1022, 10'd1);
    queue_pair(10'd511, 10'd512);
    drain();

    // Shrink below the running count: the next pair closes the frame at once,
    // then a full-scale frame of three gives the widest half range.
    write_frame_length(16'd3);
    queue_pair(10'd300, 10'd700);
    queue_pair(10'd0, 10'd1023);
    queue_pair(10'd1023, 10'd0);
    queue_pair(10'd5, 10'd5);
    drain();

    // Zero length acts as one: every pair closes a frame.
    write_frame_length(16'd0);
    queue_pair(10'd1023, 10'd0);
    queue_pair(10'd0, 10'd1023);
    drain();

    // Longest frame: nothing comes out until the length is cut back to one.
    write_frame_length(16'hFFFF);
    queue_pair(10'd800, 10'd200);
    queue_pair(10'd100, 10'd900);
    queue_pair(10'd400, 10'd400);
    drain();
    write_frame_length(16'd1);
    queue_pair(10'd0, 10'd0);
    queue_pair(10'd1023, 10'd1023);
    drain();

    // Random phases: mostly short frames so reports stay frequent, some long or
    // huge lengths that leave a frame open for the next phase to cut short.
    phase        = 0;
    random_pairs = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      pick = $urandom_range(99);
      if (pick < 70)      len = FRAME_LEN_W'($urandom_range(12, 1));
      else if (pick < 88) len = FRAME_LEN_W'($urandom_range(100, 13));
      else if (pick < 92) len = '0;
      else                len = FRAME_LEN_W'($urandom_range(65535, 0));
      write_frame_length(len);
      steady = (phase >= 8 && phase < 14);
      style  = $urandom_range(3);
      cen_a  = $urandom_range(1023);
      cen_b  = $urandom_range(1023);
      amp    = $urandom_range(300);
      n      = $urandom_range(60, 5);
      repeat (n) begin
        case (style)
          0: begin
            a = SAMPLE_BITS'($urandom);
            b = SAMPLE_BITS'($urandom);
          end
          1, 2: begin
            // Encoder-like: each channel swings around its own offset.
            a = to_code(cen_a + int'($urandom_range(2 * amp)) - amp);
            b = to_code(cen_b + int'($urandom_range(2 * amp)) - amp);
          end
          default: begin
            a = $urandom_range(1) ? MIN_RESET : MAX_RESET;
            b = $urandom_range(1) ? MIN_RESET : MAX_RESET;
          end
        endcase
        queue_pair(a, b);
      end
      random_pairs += n;
      phase++;
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> dual_channel_offset_amplitude_estimator_unit.f
+incdir+sv
sv/dcoae_pkg.sv
sv/dcoae_lane.sv
sv/dcoae_merge.sv
sv/dual_channel_offset_amplitude_estimator_unit.sv
sv/dcoae_checker.sv
dv/testbench.sv
